// ===== design/vlpds_pkg.sv =====
`default_nettype none

package vlpds_pkg;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_SEARCH = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        t_req               req_type;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        t_status    status;
        logic       found;
        logic [4:0] entry_count;
    } t_out;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_MARK,
        CELL_EVEN,
        CELL_ODD
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic signed [31:0] value;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MARK,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== design/vlpds_cell.sv =====
`default_nettype none

module vlpds_cell #(
    parameter int IDX = 0
) (
    input  wire                    i_clk,
    input  vlpds_pkg::t_cell_ctl   i_ctl,
    input  wire                    i_in_list,
    input  wire signed [31:0]      i_left_data,
    input  wire                    i_left_hole,
    input  wire signed [31:0]      i_right_data,
    input  wire                    i_right_hole,
    output logic signed [31:0]     o_data,
    output logic                   o_hole,
    output logic                   o_eq
);

    localparam logic IsOdd = ((IDX % 2) == 1);

    logic signed [31:0] r_data;
    logic               r_hole;
    logic signed [31:0] n_data;
    logic               n_hole;
    logic               w_eq;
    logic               w_lower;

    assign w_eq   = (r_data == i_ctl.value);
    assign o_eq   = w_eq && i_in_list;
    assign o_data = r_data;
    assign o_hole = r_hole;

    // odd-even transposition: holes sink toward the tail, live entries keep order
    always_comb begin
        n_data  = r_data;
        n_hole  = r_hole;
        w_lower = 1'b0;
        case (i_ctl.op)
            vlpds_pkg::CELL_PUSH: begin
                n_data = i_left_data;
            end
            vlpds_pkg::CELL_POP: begin
                n_data = i_right_data;
            end
            vlpds_pkg::CELL_MARK: begin
                n_hole = !i_in_list || w_eq;
            end
            vlpds_pkg::CELL_EVEN, vlpds_pkg::CELL_ODD: begin
                w_lower = (i_ctl.op == vlpds_pkg::CELL_ODD) ? IsOdd : !IsOdd;
                if (w_lower) begin
                    if (r_hole && !i_right_hole) begin
                        n_data = i_right_data;
                        n_hole = 1'b0;
                    end
                end else begin
                    if (!r_hole && i_left_hole) begin
                        n_hole = 1'b1;
                    end
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_hole <= n_hole;
    end

endmodule

`default_nettype wire

// ===== design/value_list_push_delete_search_core.sv =====
`default_nettype none

// channel | direction | handshake                   | payload
// in      | to core   | i_in_valid / o_in_stall     | i_in_data  (vlpds_pkg::t_in)
// out     | from core | o_out_valid / i_out_stall   | o_out_data (vlpds_pkg::t_out)
//
// push and remove front finish in the accept cycle; the result is registered at that edge
// remove all matching and search pass through a compare state, a scan state in which a scan
// counter tallies matches (remove also runs DEPTH odd-even rounds there), and a result state
// reset clears the entry count, control state and output valid; cell contents stay undefined
// a new request is taken only when idle and the output register is free or being drained
// a stalled result holds the core in its final state until it is taken

module value_list_push_delete_search_core #(
    parameter int DEPTH = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  vlpds_pkg::t_in     i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output vlpds_pkg::t_out    o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    vlpds_pkg::t_state    r_state;
    vlpds_pkg::t_state    n_state;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [CW-1:0]        r_hits;
    logic [CW-1:0]        n_hits;
    logic [IW-1:0]        r_idx;
    logic [IW-1:0]        n_idx;
    vlpds_pkg::t_req      r_req;
    logic signed [31:0]   r_value;
    logic [DEPTH-1:0]     r_match;
    logic                 r_out_valid;
    vlpds_pkg::t_out      r_out;
    vlpds_pkg::t_out      n_out;
    logic                 n_load;
    logic                 w_out_free;
    logic                 w_accept;
    vlpds_pkg::t_cell_ctl w_ctl;
    logic [CW+4:0]        w_count_ext;

    logic signed [31:0]   w_data [DEPTH];
    logic [DEPTH-1:0]     w_hole;
    logic [DEPTH-1:0]     w_eq;
    logic [DEPTH-1:0]     w_in_list;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == vlpds_pkg::S_IDLE) && w_out_free);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] w_l_data;
        logic               w_l_hole;
        logic signed [31:0] w_r_data;
        logic               w_r_hole;

        assign w_in_list[g] = (r_count > CW'(g));

        if (g == 0) begin : g_first
            assign w_l_data = w_ctl.value;
            assign w_l_hole = 1'b0;
        end else begin : g_mid_l
            assign w_l_data = w_data[g-1];
            assign w_l_hole = w_hole[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_r_data = '0;
            assign w_r_hole = 1'b1;
        end else begin : g_mid_r
            assign w_r_data = w_data[g+1];
            assign w_r_hole = w_hole[g+1];
        end

        vlpds_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_in_list    (w_in_list[g]),
            .i_left_data  (w_l_data),
            .i_left_hole  (w_l_hole),
            .i_right_data (w_r_data),
            .i_right_hole (w_r_hole),
            .o_data       (w_data[g]),
            .o_hole       (w_hole[g]),
            .o_eq         (w_eq[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_hits      = r_hits;
        n_idx       = r_idx;
        n_load      = 1'b0;
        n_out       = r_out;
        w_ctl.op    = vlpds_pkg::CELL_HOLD;
        w_ctl.value = r_value;
        w_count_ext = '0;
        unique case (r_state)
            vlpds_pkg::S_IDLE: begin
                w_ctl.value = i_in_data.value;
                if (w_accept) begin
                    n_out.found  = 1'b0;
                    n_out.status = vlpds_pkg::ST_DONE;
                    unique case (i_in_data.req_type)
                        vlpds_pkg::REQ_PUSH: begin
                            n_load = 1'b1;
                            if (r_count >= CW'(DEPTH)) begin
                                n_out.status = vlpds_pkg::ST_FULL;
                            end else begin
                                w_ctl.op = vlpds_pkg::CELL_PUSH;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        vlpds_pkg::REQ_POP: begin
                            n_load = 1'b1;
                            if (r_count == '0) begin
                                n_out.status = vlpds_pkg::ST_MISS;
                            end else begin
                                w_ctl.op = vlpds_pkg::CELL_POP;
                                n_count  = r_count - CW'(1);
                            end
                        end
                        default: begin
                            n_state = vlpds_pkg::S_MARK;
                        end
                    endcase
                    w_count_ext       = {5'd0, n_count};
                    n_out.entry_count = w_count_ext[4:0];
                end
            end
            vlpds_pkg::S_MARK: begin
                w_ctl.op = vlpds_pkg::CELL_MARK;
                n_hits   = '0;
                n_idx    = '0;
                n_state  = vlpds_pkg::S_SCAN;
            end
            vlpds_pkg::S_SCAN: begin
                if (r_req == vlpds_pkg::REQ_REMOVE) begin
                    w_ctl.op = r_idx[0] ? vlpds_pkg::CELL_ODD : vlpds_pkg::CELL_EVEN;
                end
                n_hits = r_hits + CW'(r_match[r_idx]);
                n_idx  = r_idx + IW'(1);
                if (r_idx == IW'(DEPTH - 1)) begin
                    n_state = vlpds_pkg::S_DONE;
                end
            end
            vlpds_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_load       = 1'b1;
                    n_state      = vlpds_pkg::S_IDLE;
                    n_out.found  = 1'b0;
                    n_out.status = vlpds_pkg::ST_DONE;
                    if (r_req == vlpds_pkg::REQ_REMOVE) begin
                        if (r_hits == '0) begin
                            n_out.status = vlpds_pkg::ST_MISS;
                        end else begin
                            n_count = r_count - r_hits;
                        end
                    end else begin
                        n_out.found = (r_hits != '0);
                    end
                    w_count_ext       = {5'd0, n_count};
                    n_out.entry_count = w_count_ext[4:0];
                end
            end
            default: begin
                n_state = vlpds_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vlpds_pkg::S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hits <= n_hits;
        if (n_load) begin
            r_out <= n_out;
        end
        if (w_accept) begin
            r_req   <= i_in_data.req_type;
            r_value <= i_in_data.value;
        end
        if (r_state == vlpds_pkg::S_MARK) begin
            r_match <= w_eq;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != vlpds_pkg::S_IDLE) |-> o_in_stall)
        else $error("input taken while a request is in progress");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_data.req_type == vlpds_pkg::REQ_PUSH)
            && (r_count < CW'(DEPTH)))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the list");

    a_hits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vlpds_pkg::S_DONE) |-> (r_hits <= r_count))
        else $error("more matches than entries");
`endif

endmodule

`default_nettype wire
